@@ rtl/core/bankers_safety_check_macros.svh @@
// Assertion helper macros for the safety check block.
`ifndef BANKERS_SAFETY_CHECK_MACROS_SVH
`define BANKERS_SAFETY_CHECK_MACROS_SVH
// implication checked on every clock, off during reset
`define BSC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsc assertion failed");
// next-cycle implication
`define BSC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsc assertion failed");
`endif

@@ rtl/core/bsc_pkg.sv @@
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants for the safety check block.
// ----------------------------------------------------------------------------
package bsc_pkg;
  localparam int MaxProc = 16;
  localparam int MaxRes = 16;
  localparam int ValueBits = 16;
  localparam int ProcBits = 4;
  localparam int ResBits = 4;
  localparam int AddrBits = 8;
  localparam int WorkBits = 21;

  localparam logic [1:0] REQ_LOAD_PROC = 2'd0;
  localparam logic [1:0] REQ_LOAD_AVAIL = 2'd1;
  localparam logic [1:0] REQ_CHECK = 2'd2;

  localparam logic [0:0] CFG_PROC_COUNT = 1'd0;
  localparam logic [0:0] CFG_RES_COUNT = 1'd1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] proc_index;
    logic [3:0] res_index;
    logic [15:0] max_value;
    logic [15:0] alloc_value;
    logic [15:0] avail_value;
  } req_t;

  typedef struct packed {
    logic safe;
    logic [3:0] proc_id;
    logic last;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_TEST_RD, ST_TEST, ST_ADD_RD, ST_ADD,
    ST_NEXT, ST_UNSAFE, ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_proc;
    logic load_avail;
    logic init_work;   // copy avail into work for active resources, zero the rest
    logic clr_flags;
    logic rd_issue;    // read tables at current proc/res
    logic res_zero;
    logic res_inc;
    logic fail_clr;    // set fit flag true
    logic fail_upd;    // fold compare into fit flag
    logic work_add;
    logic mark_done;   // finish flag, append sequence
    logic proc_zero;
    logic proc_inc;
    logic prog_clr;
    logic emit_zero;
    logic emit_inc;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic res_last;
    logic proc_last;
    logic cur_finished;
    logic fits;
    logic progress;
    logic all_done;
    logic emit_last;
  } dp_stat_t;
endpackage

@@ rtl/core/bsc_datapath.sv @@
// ----------------------------------------------------------------------------
// bsc_datapath
// Tables, work vector, flags, sequence store and counters.
// ----------------------------------------------------------------------------
module bsc_datapath (
  input  logic              clk,
  input  logic              rst,
  input  bsc_pkg::req_t     req,
  input  logic [4:0]        proc_count,
  input  logic [4:0]        res_count,
  input  bsc_pkg::dp_cmd_t  cmd,
  output bsc_pkg::dp_stat_t stat,
  output logic [3:0]        emit_id
);
  logic [15:0] need_mem [0:255];
  logic [15:0] alloc_mem [0:255];
  logic [15:0] avail_mem [0:15];
  logic [15:0] need_rd;
  logic [15:0] alloc_rd;
  logic [20:0] work [0:15];
  logic [15:0] finished;
  logic [3:0]  seq [0:15];
  logic [4:0]  done_count;
  logic [3:0]  proc_ptr;
  logic [3:0]  res_ptr;
  logic [3:0]  emit_ptr;
  logic        fit;
  logic        progress;
  logic [3:0]  np_m1;
  logic [3:0]  nr_m1;
  logic [15:0] need_val;

  // clamp counts: zero acts as one, top is 16
  assign np_m1 = (proc_count == 5'd0) ? 4'd0 :
                 (proc_count > 5'd16) ? 4'd15 : 4'(proc_count - 5'd1);
  assign nr_m1 = (res_count == 5'd0) ? 4'd0 :
                 (res_count > 5'd16) ? 4'd15 : 4'(res_count - 5'd1);
  assign need_val = (req.alloc_value > req.max_value) ? 16'd0 :
                    16'(req.max_value - req.alloc_value);

  always_ff @(posedge clk) begin
    if (cmd.load_proc) begin
      need_mem[{req.proc_index, req.res_index}] <= need_val;
      alloc_mem[{req.proc_index, req.res_index}] <= req.alloc_value;
    end
    if (cmd.rd_issue) begin
      need_rd <= need_mem[{proc_ptr, res_ptr}];
      alloc_rd <= alloc_mem[{proc_ptr, res_ptr}];
    end
    if (cmd.load_avail) avail_mem[req.res_index] <= req.avail_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) work[i] <= '0;
      finished <= '0;
      done_count <= '0;
      proc_ptr <= '0;
      res_ptr <= '0;
      emit_ptr <= '0;
      fit <= 1'b1;
      progress <= 1'b0;
    end else begin
      if (cmd.init_work) begin
        for (int i = 0; i < 16; i++)
          work[i] <= (4'(i) <= nr_m1) ? {5'd0, avail_mem[i]} : '0;
      end
      if (cmd.work_add) work[res_ptr] <= work[res_ptr] + {5'd0, alloc_rd};
      if (cmd.clr_flags) begin
        finished <= '0;
        done_count <= '0;
      end
      if (cmd.mark_done) begin
        finished[proc_ptr] <= 1'b1;
        seq[done_count[3:0]] <= proc_ptr;
        done_count <= done_count + 5'd1;
      end
      // a pass that ends on a marked process had progress anyway
      if (cmd.prog_clr) progress <= 1'b0;
      else if (cmd.mark_done) progress <= 1'b1;
      if (cmd.res_zero) res_ptr <= '0;
      else if (cmd.res_inc) res_ptr <= res_ptr + 4'd1;
      if (cmd.proc_zero) proc_ptr <= '0;
      else if (cmd.proc_inc) proc_ptr <= proc_ptr + 4'd1;
      if (cmd.fail_clr) fit <= 1'b1;
      else if (cmd.fail_upd && ({5'd0, need_rd} > work[res_ptr])) fit <= 1'b0;
      if (cmd.emit_zero) emit_ptr <= '0;
      else if (cmd.emit_inc) emit_ptr <= emit_ptr + 4'd1;
    end
  end

  assign stat.res_last = (res_ptr == nr_m1);
  assign stat.proc_last = (proc_ptr == np_m1);
  assign stat.cur_finished = finished[proc_ptr];
  assign stat.fits = fit;
  assign stat.progress = progress;
  assign stat.all_done = (done_count == ({1'b0, np_m1} + 5'd1));
  assign stat.emit_last = (emit_ptr == np_m1);
  assign emit_id = seq[emit_ptr];
endmodule

@@ rtl/core/bsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// bsc_ctrl
// Sequencer for loads, the pass/process/resource scan and result output.
// ----------------------------------------------------------------------------
module bsc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        req_type,
  input  bsc_pkg::dp_stat_t stat,
  output bsc_pkg::dp_cmd_t  cmd,
  output logic              busy,
  output logic              emit,
  output logic              emit_unsafe
);
  bsc_pkg::state_t state, state_next;
  logic go;

  assign go = start && (state == bsc_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= bsc_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      bsc_pkg::ST_IDLE:
        if (go && req_type == bsc_pkg::REQ_CHECK) state_next = bsc_pkg::ST_INIT;
      bsc_pkg::ST_INIT: state_next = bsc_pkg::ST_NEXT;
      bsc_pkg::ST_TEST_RD: state_next = bsc_pkg::ST_TEST;
      bsc_pkg::ST_TEST:
        if (stat.res_last) state_next = bsc_pkg::ST_ADD_RD;
        else state_next = bsc_pkg::ST_TEST_RD;
      bsc_pkg::ST_ADD_RD:
        // a miss on the last process ends the pass, unsafe if it made no progress
        if (!stat.fits && stat.proc_last && !stat.progress)
          state_next = bsc_pkg::ST_UNSAFE;
        else if (!stat.fits) state_next = bsc_pkg::ST_NEXT;
        else state_next = bsc_pkg::ST_ADD;
      bsc_pkg::ST_ADD:
        if (stat.res_last) state_next = bsc_pkg::ST_NEXT;
        else state_next = bsc_pkg::ST_ADD_RD;
      bsc_pkg::ST_NEXT:
        // decides on the process at proc_ptr; wraps at end of a pass
        if (stat.all_done) state_next = bsc_pkg::ST_EMIT;
        else if (!stat.cur_finished) state_next = bsc_pkg::ST_TEST_RD;
        else if (stat.proc_last && !stat.progress) state_next = bsc_pkg::ST_UNSAFE;
      bsc_pkg::ST_UNSAFE: state_next = bsc_pkg::ST_IDLE;
      bsc_pkg::ST_EMIT:
        if (stat.emit_last) state_next = bsc_pkg::ST_IDLE;
      default: state_next = bsc_pkg::ST_IDLE;
    endcase
  end

  // ST_NEXT is entered with proc_ptr pointing at the candidate. A fitted
  // process is marked in its last ST_ADD cycle, as ptr advances for ST_NEXT.
  logic adv;
  always_comb begin
    cmd = '0;
    busy = (state != bsc_pkg::ST_IDLE);
    emit = 1'b0;
    emit_unsafe = 1'b0;
    adv = 1'b0;
    case (state)
      bsc_pkg::ST_IDLE: begin
        cmd.load_proc = go && req_type == bsc_pkg::REQ_LOAD_PROC;
        cmd.load_avail = go && req_type == bsc_pkg::REQ_LOAD_AVAIL;
      end
      bsc_pkg::ST_INIT: begin
        cmd.init_work = 1'b1;
        cmd.clr_flags = 1'b1;
        cmd.proc_zero = 1'b1;
        cmd.prog_clr = 1'b1;
        cmd.res_zero = 1'b1;
        cmd.fail_clr = 1'b1;
        cmd.emit_zero = 1'b1;
      end
      bsc_pkg::ST_TEST_RD: cmd.rd_issue = 1'b1;
      bsc_pkg::ST_TEST: begin
        cmd.fail_upd = 1'b1;
        if (stat.res_last) cmd.res_zero = 1'b1;
        else cmd.res_inc = 1'b1;
      end
      bsc_pkg::ST_ADD_RD: begin
        cmd.rd_issue = stat.fits;
        if (!stat.fits) begin
          cmd.fail_clr = 1'b1;
          adv = 1'b1;
          if (stat.proc_last) cmd.prog_clr = 1'b1;
        end
      end
      bsc_pkg::ST_ADD: begin
        cmd.work_add = 1'b1;
        if (stat.res_last) begin
          cmd.res_zero = 1'b1;
          cmd.mark_done = 1'b1;
          cmd.fail_clr = 1'b1;
          adv = 1'b1;
          if (stat.proc_last) cmd.prog_clr = 1'b1;
        end else begin
          cmd.res_inc = 1'b1;
        end
      end
      bsc_pkg::ST_NEXT: begin
        if (!stat.all_done && stat.cur_finished) begin
          adv = 1'b1;
          if (stat.proc_last) cmd.prog_clr = 1'b1;
        end
      end
      bsc_pkg::ST_UNSAFE: begin
        emit = 1'b1;
        emit_unsafe = 1'b1;
      end
      bsc_pkg::ST_EMIT: begin
        emit = 1'b1;
        cmd.emit_inc = 1'b1;
      end
      default: ;
    endcase
    if (adv) begin
      if (stat.proc_last) cmd.proc_zero = 1'b1;
      else cmd.proc_inc = 1'b1;
    end
  end
endmodule

@@ rtl/core/bankers_safety_check.sv @@
// ----------------------------------------------------------------------------
// bankers_safety_check
// Banker's algorithm safety test: table loads and a sequential safety scan.
// ----------------------------------------------------------------------------
// channel  | handshake          | payload
// request  | start / busy       | req (bsc_pkg::req_t)
// result   | result_valid       | result (bsc_pkg::result_t)
// config   | cfg_we / cfg_index | cfg_data
//
// A load is written while idle. A check runs an init step, then visits each
// process; an unfinished process gets a table read and test per resource,
// then a read and add per resource (stopping at the first read step when
// it does not fit), over up to P passes; then P result beats (or one unsafe
// beat), each beat registered after it is formed. The shared table read
// port sets the read steps. Reset is synchronous; no clearing pass. Results cannot be stalled.
module bankers_safety_check (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bsc_pkg::req_t     req,
  output logic              result_valid,
  output bsc_pkg::result_t  result,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [4:0]        cfg_data
);
  logic [4:0] proc_count;
  logic [4:0] res_count;
  bsc_pkg::dp_cmd_t  cmd;
  bsc_pkg::dp_stat_t stat;
  logic [3:0] emit_id;
  logic emit;
  logic emit_unsafe;

  always_ff @(posedge clk) begin
    if (rst) begin
      proc_count <= 5'd1;
      res_count <= 5'd1;
    end else if (cfg_we) begin
      if (cfg_index == bsc_pkg::CFG_PROC_COUNT) proc_count <= cfg_data;
      else res_count <= cfg_data;
    end
  end

  bsc_ctrl u_ctrl (
    .clk, .rst, .start, .req_type(req.req_type), .stat, .cmd, .busy,
    .emit, .emit_unsafe
  );

  bsc_datapath u_dp (
    .clk, .rst, .req, .proc_count, .res_count, .cmd, .stat, .emit_id
  );

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else result_valid <= emit;
    result.safe <= !emit_unsafe;
    result.proc_id <= emit_unsafe ? 4'd0 : emit_id;
    result.last <= emit_unsafe || stat.emit_last;
  end
endmodule

@@ rtl/core/bsc_checker.sv @@
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks for the safety check block.
// ----------------------------------------------------------------------------
`include "bankers_safety_check_macros.svh"
module bsc_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             result_valid,
  input bsc_pkg::result_t result
);
  `BSC_ASSERT_IMP(a_unsafe_last, result_valid && !result.safe, result.last)
  `BSC_ASSERT_IMP(a_unsafe_id, result_valid && !result.safe, result.proc_id == 4'd0)
  `BSC_ASSERT_NXT(a_idle_after_last, result_valid && result.last, !result_valid)
  `BSC_ASSERT_NXT(a_no_result_idle, !busy && !start, !result_valid)
endmodule

bind bankers_safety_check bsc_checker u_chk (
  .clk, .rst, .start, .busy, .result_valid, .result
);

@@ sim/tb_bankers_safety_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bankers_safety_check
// Drives config writes, table loads and safety checks through the ports and compares
// each result beat against an in-bench safety scan of the shadow tables.
// ----------------------------------------------------------------------------
module tb_bankers_safety_check;
  localparam logic [1:0] ReqUnknown = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  bsc_pkg::req_t req = '0;
  logic result_valid;
  bsc_pkg::result_t result;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = bsc_pkg::CFG_PROC_COUNT;
  logic [4:0] cfg_data = '0;

  bankers_safety_check u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .result_valid(result_valid), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // shadow of the block's tables and registers
  logic [15:0] need_sh [bsc_pkg::MaxProc][bsc_pkg::MaxRes];
  logic [15:0] alloc_sh [bsc_pkg::MaxProc][bsc_pkg::MaxRes];
  logic [15:0] avail_sh [bsc_pkg::MaxRes];
  bit proc_wr [bsc_pkg::MaxProc][bsc_pkg::MaxRes];
  bit avail_wr [bsc_pkg::MaxRes];
  int n_proc = 1;
  int n_res = 1;

  bsc_pkg::result_t seq_expected[$];
  int errors = 0;
  int send_idle_pct = 0;
  longint cycles = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic int clamp_count(input logic [4:0] v, input int lim);
    if (v == 5'd0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  // safety scan over the shadow tables; queues the expected beats
  task automatic predict_safety();
    logic [20:0] work [bsc_pkg::MaxRes];
    bit done [bsc_pkg::MaxProc];
    int order [bsc_pkg::MaxProc];
    int cnt;
    bit progress;
    bit ok;
    bsc_pkg::result_t r;
    cnt = 0;
    for (int i = 0; i < bsc_pkg::MaxRes; i++)
      work[i] = (i < n_res) ? {5'd0, avail_sh[i]} : '0;
    for (int p = 0; p < bsc_pkg::MaxProc; p++) done[p] = 1'b0;
    while (cnt < n_proc) begin
      progress = 1'b0;
      for (int p = 0; p < n_proc; p++) begin
        if (done[p]) continue;
        ok = 1'b1;
        for (int i = 0; i < n_res; i++)
          if ({5'd0, need_sh[p][i]} > work[i]) ok = 1'b0;
        if (!ok) continue;
        for (int i = 0; i < n_res; i++) work[i] += {5'd0, alloc_sh[p][i]};
        order[cnt++] = p;
        done[p] = 1'b1;
        progress = 1'b1;
      end
      if (!progress) begin
        r.safe = 1'b0; r.proc_id = 4'd0; r.last = 1'b1;
        seq_expected.push_back(r);
        return;
      end
    end
    for (int k = 0; k < n_proc; k++) begin
      r.safe = 1'b1; r.proc_id = order[k][3:0]; r.last = (k == n_proc - 1);
      seq_expected.push_back(r);
    end
  endtask

  // true when every table entry a check reads is written
  function automatic bit tables_ready();
    for (int i = 0; i < n_res; i++) begin
      if (!avail_wr[i]) return 1'b0;
      for (int p = 0; p < n_proc; p++) if (!proc_wr[p][i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bsc_pkg::req_t rand_req(input logic [1:0] t);
    bsc_pkg::req_t b;
    b.req_type = t;
    b.proc_index = 4'($urandom);
    b.res_index = 4'($urandom);
    b.max_value = 16'($urandom);
    b.alloc_value = 16'($urandom);
    b.avail_value = 16'($urandom);
    return b;
  endfunction

  // send one beat; start stays high when the next beat follows directly
  task automatic send_beat(input bsc_pkg::req_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    req <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (b.req_type)
      bsc_pkg::REQ_LOAD_PROC: begin
        need_sh[b.proc_index][b.res_index] =
          (b.alloc_value > b.max_value) ? 16'd0 : b.max_value - b.alloc_value;
        alloc_sh[b.proc_index][b.res_index] = b.alloc_value;
        proc_wr[b.proc_index][b.res_index] = 1'b1;
      end
      bsc_pkg::REQ_LOAD_AVAIL: begin
        avail_sh[b.res_index] = b.avail_value;
        avail_wr[b.res_index] = 1'b1;
      end
      bsc_pkg::REQ_CHECK: predict_safety();
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (seq_expected.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [0:0] idx, input logic [4:0] v);
    drain();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == bsc_pkg::CFG_PROC_COUNT) n_proc = clamp_count(v, bsc_pkg::MaxProc);
    else n_res = clamp_count(v, bsc_pkg::MaxRes);
  endtask

  task automatic load_proc(input int p, input int i, input int mx, input int al);
    bsc_pkg::req_t b;
    b = '0;
    b.req_type = bsc_pkg::REQ_LOAD_PROC; b.proc_index = 4'(p); b.res_index = 4'(i);
    b.max_value = 16'(mx); b.alloc_value = 16'(al); b.avail_value = 16'($urandom);
    send_beat(b);
  endtask

  task automatic load_avail(input int i, input int av);
    bsc_pkg::req_t b;
    b = rand_req(bsc_pkg::REQ_LOAD_AVAIL);
    b.res_index = 4'(i); b.avail_value = 16'(av);
    send_beat(b);
  endtask

  task automatic run_check();
    send_beat(rand_req(bsc_pkg::REQ_CHECK));
  endtask

  task automatic send_unknown();
    send_beat(rand_req(ReqUnknown));
  endtask

  // fill the active region; small needs make safe states likely
  task automatic fill_tables(input int scale, input bit only_missing);
    int mx;
    for (int i = 0; i < n_res; i++)
      if (!only_missing || !avail_wr[i]) load_avail(i, $urandom_range(scale));
    for (int p = 0; p < n_proc; p++)
      for (int i = 0; i < n_res; i++) begin
        if (only_missing && proc_wr[p][i]) continue;
        mx = $urandom_range(scale);
        load_proc(p, i, mx, $urandom_range(mx));
      end
  endtask

  task automatic test_directed();
    write_cfg(bsc_pkg::CFG_PROC_COUNT, 5'd1);
    write_cfg(bsc_pkg::CFG_RES_COUNT, 5'd1);
    load_avail(0, 0);
    load_proc(0, 0, 16'hFFFF, 16'hFFFF);     // need zero
    run_check();
    load_proc(0, 0, 16'h0001, 16'hFFFF);     // alloc above max clamps need
    run_check();
    load_proc(0, 0, 16'hFFFF, 0);            // unsafe
    run_check();
    send_unknown();
    write_cfg(bsc_pkg::CFG_PROC_COUNT, 5'd2);
    load_avail(0, 16'hFFFF);
    load_proc(1, 0, 0, 16'hFFFF);            // work grows past 16 bits
    load_proc(0, 0, 16'hFFFF, 0);
    run_check();
    load_avail(15, 16'h8000);
    load_proc(15, 15, 16'h5555, 16'hAAAA);
    write_cfg(bsc_pkg::CFG_PROC_COUNT, 5'd0);  // zero reads as one
    run_check();
    write_cfg(bsc_pkg::CFG_RES_COUNT, 5'd0);
    run_check();
  endtask

  task automatic test_extremes();
    write_cfg(bsc_pkg::CFG_PROC_COUNT, 5'd31);  // clamps to max
    write_cfg(bsc_pkg::CFG_RES_COUNT, 5'd2);
    fill_tables(65535, 1'b0);
    run_check();
    write_cfg(bsc_pkg::CFG_PROC_COUNT, 5'd1);
    write_cfg(bsc_pkg::CFG_RES_COUNT, 5'd31);   // clamps to max
    fill_tables(65535, 1'b0);
    run_check();
  endtask

  task automatic test_random(input int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) == 0) begin
        write_cfg(bsc_pkg::CFG_PROC_COUNT, 5'($urandom_range(16, 1)));
        write_cfg(bsc_pkg::CFG_RES_COUNT, 5'($urandom_range(4, 1)));
      end
      case ($urandom_range(9))
        0: load_proc($urandom_range(n_proc - 1), $urandom_range(n_res - 1),
                     $urandom_range(40), $urandom_range(30));
        1: load_avail($urandom_range(15), $urandom);
        2: send_unknown();
        3: load_proc($urandom_range(15), $urandom_range(15), $urandom, $urandom);
        default: begin
          if (!tables_ready()) fill_tables(20, 1'b1);
          run_check();
        end
      endcase
      sent++;
    end
  endtask

  initial begin
    for (int p = 0; p < bsc_pkg::MaxProc; p++)
      for (int i = 0; i < bsc_pkg::MaxRes; i++) proc_wr[p][i] = 1'b0;
    for (int i = 0; i < bsc_pkg::MaxRes; i++) avail_wr[i] = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 21;
    test_directed();
    test_extremes();
    test_random(35);
    drain();                                 // pause until all results are in
    send_idle_pct = 61;
    test_random(35);
    send_idle_pct = 0;
    test_random(35);
    drain();
    repeat (200) @(negedge clk);
    if (errors == 0 && seq_expected.size() == 0)
      $display("PASS bankers_safety_check");
    else
      $display("FAIL bankers_safety_check");
    $finish;
  end

  // result checker: every strobed beat is checked against the oldest entry
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && result_valid) begin
      if (seq_expected.size() == 0)
        report_mismatch($sformatf("unexpected beat %p", result));
      else begin
        if (result.safe !== seq_expected[0].safe)
          report_mismatch($sformatf("safe %b exp %b", result.safe,
                                    seq_expected[0].safe));
        if (result.proc_id !== seq_expected[0].proc_id)
          report_mismatch($sformatf("proc_id %0d exp %0d", result.proc_id,
                                    seq_expected[0].proc_id));
        if (result.last !== seq_expected[0].last)
          report_mismatch($sformatf("last %b exp %b", result.last,
                                    seq_expected[0].last));
        void'(seq_expected.pop_front());
      end
    end
    if (cycles > 3000000) begin
      $display("FAIL bankers_safety_check");
      $finish;
    end
  end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/bsc_pkg.sv
rtl/core/bsc_datapath.sv
rtl/core/bsc_ctrl.sv
rtl/core/bankers_safety_check.sv
rtl/core/bsc_checker.sv
sim/tb_bankers_safety_check.sv
